### rtl/core/wpp_pkg.sv
package wpp_pkg;

  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_RIFF_WAVE = 3'd0;
  localparam logic [2:0] ERR_SHORT_FMT = 3'd1;
  localparam logic [2:0] ERR_NOT_PCM   = 3'd2;
  localparam logic [2:0] ERR_CHANNELS  = 3'd3;
  localparam logic [2:0] ERR_BITS      = 3'd4;
  localparam logic [2:0] ERR_NO_DATA   = 3'd5;

  // four-character tags, little endian as they arrive
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] DEFAULT_RATE = 32'd22050;
  localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
  localparam logic [4:0]  DEFAULT_BITS = 5'd8;
  localparam logic [1:0]  DEFAULT_CH   = 2'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] sample;
    logic [1:0]  channels;
    logic [4:0]  bits;
    logic [31:0] rate;
    logic [30:0] frames;
    logic [2:0]  err;
    logic        last;
  } res_t;

endpackage

### rtl/core/wpp_parse.sv
module wpp_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic [7:0]     byte_i,
  input  logic           sof_i,
  output logic           res_valid_o,
  output wpp_pkg::res_t  res_o
);

  localparam logic [3:0] PH_RIFF      = 4'd0;
  localparam logic [3:0] PH_RIFF_SIZE = 4'd1;
  localparam logic [3:0] PH_WAVE      = 4'd2;
  localparam logic [3:0] PH_CHUNK_ID  = 4'd3;
  localparam logic [3:0] PH_FMT_LEN   = 4'd4;
  localparam logic [3:0] PH_FMT_TAG   = 4'd5;
  localparam logic [3:0] PH_FMT_CH    = 4'd6;
  localparam logic [3:0] PH_FMT_RATE  = 4'd7;
  localparam logic [3:0] PH_FMT_SKIP6 = 4'd8;
  localparam logic [3:0] PH_FMT_BITS  = 4'd9;
  localparam logic [3:0] PH_FMT_REST  = 4'd10;
  localparam logic [3:0] PH_DATA_LEN  = 4'd11;
  localparam logic [3:0] PH_SAMPLES   = 4'd12;
  localparam logic [3:0] PH_IDLE      = 4'd13;
  localparam logic [3:0] PH_BAD_HDR   = 4'd14;

  logic [3:0]  phase_q, phase_d, phase_c;
  logic [1:0]  idx_q, idx_d, idx_c;
  logic [31:0] shift_q, shift_d, shift_c;
  logic [31:0] skip_q, skip_d, skip_c;
  logic [31:0] clen_q, clen_d, clen_c;
  logic [1:0]  ch_q, ch_d, ch_c;
  logic [4:0]  bits_q, bits_d, bits_c;
  logic [31:0] rate_q, rate_d, rate_c;
  logic [31:0] items_q, items_d, items_c;
  logic [7:0]  hold_q, hold_d, hold_c;

  logic          gathering, two_byte, gdone;
  logic [31:0]   acc;
  logic [31:0]   frames;
  logic [31:0]   items_dec;
  wpp_pkg::res_t res;
  logic          res_valid;

  always_comb begin
    // a start byte restarts from the reset values
    if (sof_i) begin
      phase_c = PH_RIFF;
      idx_c   = 2'd0;
      shift_c = 32'd0;
      skip_c  = 32'd0;
      clen_c  = 32'd0;
      ch_c    = wpp_pkg::DEFAULT_CH;
      bits_c  = wpp_pkg::DEFAULT_BITS;
      rate_c  = wpp_pkg::DEFAULT_RATE;
      items_c = 32'd0;
      hold_c  = 8'd0;
    end else begin
      phase_c = phase_q;
      idx_c   = idx_q;
      shift_c = shift_q;
      skip_c  = skip_q;
      clen_c  = clen_q;
      ch_c    = ch_q;
      bits_c  = bits_q;
      rate_c  = rate_q;
      items_c = items_q;
      hold_c  = hold_q;
    end
  end

  always_comb begin
    gathering = (phase_c == PH_RIFF) || (phase_c == PH_RIFF_SIZE) ||
                (phase_c == PH_WAVE) || (phase_c == PH_CHUNK_ID) ||
                (phase_c == PH_FMT_LEN) || (phase_c == PH_FMT_TAG) ||
                (phase_c == PH_FMT_CH) || (phase_c == PH_FMT_RATE) ||
                (phase_c == PH_FMT_BITS) || (phase_c == PH_DATA_LEN);
    two_byte  = (phase_c == PH_FMT_TAG) || (phase_c == PH_FMT_CH) ||
                (phase_c == PH_FMT_BITS);
    acc       = shift_c | ({24'd0, byte_i} << {idx_c, 3'b000});
    gdone     = two_byte ? (idx_c != 2'd0) : (idx_c == 2'd3);

    frames = {1'b0, acc[30:0]};
    if (ch_c == 2'd2) begin
      frames = (frames + 32'd1) >> 1;
    end
    if (bits_c == 5'd16) begin
      frames = frames >> 1;
    end
    items_dec = items_c - 32'd1;
  end

  always_comb begin
    phase_d = phase_c;
    idx_d   = idx_c;
    shift_d = shift_c;
    skip_d  = skip_c;
    clen_d  = clen_c;
    ch_d    = ch_c;
    bits_d  = bits_c;
    rate_d  = rate_c;
    items_d = items_c;
    hold_d  = hold_c;
    res_valid = 1'b0;
    res       = '0;

    if (gathering) begin
      if (gdone) begin
        shift_d = 32'd0;
        idx_d   = 2'd0;
      end else begin
        shift_d = acc;
        idx_d   = idx_c + 2'd1;
      end
    end

    unique case (phase_c)
      PH_RIFF: begin
        if (gdone) begin
          if (acc != wpp_pkg::TAG_RIFF) begin
            phase_d = PH_BAD_HDR;
            skip_d  = 32'd8;
          end else begin
            phase_d = PH_RIFF_SIZE;
          end
        end
      end
      PH_BAD_HDR: begin
        // eat the rest of the header so both tag errors report alike
        if (skip_c <= 32'd1) begin
          skip_d    = 32'd0;
          phase_d   = PH_IDLE;
          res_valid = 1'b1;
          res.kind  = wpp_pkg::KIND_ERROR;
          res.err   = wpp_pkg::ERR_RIFF_WAVE;
        end else begin
          skip_d = skip_c - 32'd1;
        end
      end
      PH_RIFF_SIZE: begin
        if (gdone) begin
          phase_d = PH_WAVE;
        end
      end
      PH_WAVE: begin
        if (gdone) begin
          if (acc != wpp_pkg::TAG_WAVE) begin
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res.kind  = wpp_pkg::KIND_ERROR;
            res.err   = wpp_pkg::ERR_RIFF_WAVE;
          end else begin
            phase_d = PH_CHUNK_ID;
          end
        end
      end
      PH_CHUNK_ID: begin
        if (gdone) begin
          if (acc == wpp_pkg::TAG_FMT) begin
            phase_d = PH_FMT_LEN;
          end else if (acc == wpp_pkg::TAG_DATA) begin
            phase_d = PH_DATA_LEN;
          end else begin
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res.kind  = wpp_pkg::KIND_ERROR;
            res.err   = wpp_pkg::ERR_NO_DATA;
          end
        end
      end
      PH_FMT_LEN: begin
        if (gdone) begin
          if (acc[31] || (acc < wpp_pkg::FMT_MIN_LEN)) begin
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res.kind  = wpp_pkg::KIND_ERROR;
            res.err   = wpp_pkg::ERR_SHORT_FMT;
          end else begin
            clen_d  = acc;
            phase_d = PH_FMT_TAG;
          end
        end
      end
      PH_FMT_TAG: begin
        if (gdone) begin
          if (acc != 32'd1) begin
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res.kind  = wpp_pkg::KIND_ERROR;
            res.err   = wpp_pkg::ERR_NOT_PCM;
          end else begin
            phase_d = PH_FMT_CH;
          end
        end
      end
      PH_FMT_CH: begin
        if (gdone) begin
          if ((acc != 32'd1) && (acc != 32'd2)) begin
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res.kind  = wpp_pkg::KIND_ERROR;
            res.err   = wpp_pkg::ERR_CHANNELS;
          end else begin
            ch_d    = acc[1:0];
            phase_d = PH_FMT_RATE;
          end
        end
      end
      PH_FMT_RATE: begin
        if (gdone) begin
          rate_d  = acc;
          skip_d  = 32'd6;
          phase_d = PH_FMT_SKIP6;
        end
      end
      PH_FMT_SKIP6, PH_FMT_REST: begin
        if (skip_c <= 32'd1) begin
          skip_d  = 32'd0;
          phase_d = (phase_c == PH_FMT_SKIP6) ? PH_FMT_BITS : PH_CHUNK_ID;
        end else begin
          skip_d = skip_c - 32'd1;
        end
      end
      PH_FMT_BITS: begin
        if (gdone) begin
          if ((acc != 32'd8) && (acc != 32'd16)) begin
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res.kind  = wpp_pkg::KIND_ERROR;
            res.err   = wpp_pkg::ERR_BITS;
          end else begin
            bits_d  = acc[4:0];
            skip_d  = clen_c - wpp_pkg::FMT_MIN_LEN;
            phase_d = (clen_c != wpp_pkg::FMT_MIN_LEN) ? PH_FMT_REST : PH_CHUNK_ID;
          end
        end
      end
      PH_DATA_LEN: begin
        if (gdone) begin
          res_valid = 1'b1;
          if (acc[31]) begin
            phase_d  = PH_IDLE;
            res.kind = wpp_pkg::KIND_ERROR;
            res.err  = wpp_pkg::ERR_NO_DATA;
          end else begin
            clen_d       = acc;
            items_d      = (ch_c == 2'd2) ? {frames[30:0], 1'b0} : frames;
            phase_d      = (frames != 32'd0) ? PH_SAMPLES : PH_IDLE;
            res.kind     = wpp_pkg::KIND_FORMAT;
            res.channels = ch_c;
            res.bits     = bits_c;
            res.rate     = rate_c;
            res.frames   = frames[30:0];
          end
        end
      end
      PH_SAMPLES: begin
        if (items_c == 32'd0) begin
          phase_d = PH_IDLE;
        end else if ((bits_c == 5'd16) && (idx_c == 2'd0)) begin
          hold_d = byte_i;
          idx_d  = 2'd1;
        end else begin
          idx_d      = 2'd0;
          items_d    = items_dec;
          res_valid  = 1'b1;
          res.kind   = wpp_pkg::KIND_SAMPLE;
          res.sample = (bits_c == 5'd16) ? {byte_i, hold_c} : {8'd0, byte_i};
          res.last   = (items_dec == 32'd0);
          if (items_dec == 32'd0) begin
            phase_d = PH_IDLE;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      idx_q   <= 2'd0;
      shift_q <= 32'd0;
      skip_q  <= 32'd0;
      clen_q  <= 32'd0;
      ch_q    <= wpp_pkg::DEFAULT_CH;
      bits_q  <= wpp_pkg::DEFAULT_BITS;
      rate_q  <= wpp_pkg::DEFAULT_RATE;
      items_q <= 32'd0;
      hold_q  <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      skip_q  <= skip_d;
      clen_q  <= clen_d;
      ch_q    <= ch_d;
      bits_q  <= bits_d;
      rate_q  <= rate_d;
      items_q <= items_d;
      hold_q  <= hold_d;
    end
  end

  assign res_valid_o = step_i && res_valid;
  assign res_o       = res;

endmodule

### rtl/core/wpp_out_stage.sv
module wpp_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  wpp_pkg::res_t  res_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output wpp_pkg::res_t  res_o
);

  logic          valid_q;
  wpp_pkg::res_t res_q;

  // free when empty or when the held word leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### rtl/core/wav_pcm_stream_parser.sv
// WAV (RIFF/WAVE PCM) byte stream parser.
// Input channel: one file byte per word on in_byte_i, with start_of_file_i
// high on the first byte of a file to restart the parse and restore the
// defaults (mono, 8 bit, 22050 Hz). Output channel: at most one result word
// per input byte: a format word once the data chunk length is known, then
// one word per sample (16-bit samples after the second byte of each pair),
// or a single error word, after which bytes are dropped until the next start.
// Both channels use valid/stall; a word moves when valid is high and stall
// low.
// An accepted byte is held in the input register, then the parse logic
// writes its result into the output register, where the receiver takes it.
// Throughput: one byte per cycle unless the receiver stalls.
// While the receiver stalls, the output word holds and the input register
// keeps one byte; in_stall_o rises once both are occupied.
// Reset empties both registers and puts the parser in its start state, as
// though a start_of_file byte were next; no clearing pass is needed.
module wav_pcm_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic signed [15:0] sample_value_o,
  output logic [1:0]  channel_count_o,
  output logic [4:0]  bits_per_sample_o,
  output logic [31:0] sample_rate_o,
  output logic [30:0] frame_count_o,
  output logic [2:0]  error_code_o,
  output logic        last_sample_o
);

  logic          in_valid_q;
  logic [7:0]    byte_q;
  logic          sof_q;
  logic          out_ready;
  logic          step;
  logic          res_valid;
  wpp_pkg::res_t res, res_out;

  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= in_byte_i;
      sof_q  <= start_of_file_i;
    end
  end

  wpp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .sof_i       (sof_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wpp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign result_kind_o     = res_out.kind;
  assign sample_value_o    = res_out.sample;
  assign channel_count_o   = res_out.channels;
  assign bits_per_sample_o = res_out.bits;
  assign sample_rate_o     = res_out.rate;
  assign frame_count_o     = res_out.frames;
  assign error_code_o      = res_out.err;
  assign last_sample_o     = res_out.last;

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output word");

  a_format_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o == wpp_pkg::KIND_FORMAT)) |->
    ((channel_count_o == 2'd1) || (channel_count_o == 2'd2)) &&
    ((bits_per_sample_o == 5'd8) || (bits_per_sample_o == 5'd16)))
    else $error("format word with bad channel count or width");

  a_err_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (result_kind_o != wpp_pkg::KIND_ERROR)) |->
    (error_code_o == 3'd0))
    else $error("error code set on a non-error word");

  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((result_kind_o == wpp_pkg::KIND_FORMAT) ||
                     (result_kind_o == wpp_pkg::KIND_SAMPLE) ||
                     (result_kind_o == wpp_pkg::KIND_ERROR)))
    else $error("unknown result kind");

endmodule
